[hw/rtl/fp32_gemm_tile_accumulator_assert.svh]
// assertion macros for the tile accumulator
`ifndef FP32_GEMM_TILE_ACCUMULATOR_ASSERT_SVH
`define FP32_GEMM_TILE_ACCUMULATOR_ASSERT_SVH
// implication checked on every clock, muted during reset
`define FGA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication checked on every clock, muted during reset
`define FGA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[hw/rtl/fga_pkg.sv]
package fga_pkg;
    localparam int unsigned LANES = 4;
    localparam logic [31:0] DEFAULT_NAN = 32'hFFC00000;
    localparam logic [31:0] QNAN_BIT = 32'h00400000;
    localparam logic CMD_ACC = 1'b0;
    localparam logic CMD_PRELOAD = 1'b1;
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef struct packed {
        logic        command;
        logic [1:0]  row_select;
        logic [31:0] a_0;
        logic [31:0] a_1;
        logic [31:0] a_2;
        logic [31:0] a_3;
        logic [31:0] b_0;
        logic [31:0] b_1;
        logic [31:0] b_2;
        logic [31:0] b_3;
        logic        last_step;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  out_row;
        logic [1:0]  out_col;
        logic [31:0] c_value;
        logic        last_result;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_ALIGN, ST_NORM, ST_ROUND, ST_EMIT
    } t_state;

    // stage one products and special cases for one lane
    typedef struct packed {
        logic        special;
        logic [31:0] special_val;
        logic        ps;
        logic        sc;
        logic        czero;
        logic [47:0] prod;
        logic signed [11:0] xe;
        logic [23:0] cm;
        logic signed [11:0] ye;
    } t_mul;

    // aligned sum before normalization
    typedef struct packed {
        logic        special;
        logic [31:0] special_val;
        logic        rs;
        logic        zero_sum;
        logic [75:0] r;
        logic signed [11:0] re;
    } t_sum;
endpackage

[hw/rtl/fga_if.sv]
interface fga_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/fp32_gemm_tile_accumulator.sv]
// fp32 gemm tile accumulator: C = A*B + C for a TILE_ROWS x TILE_COLS tile
// i_in (fga_if sink): one beat per item. command preload writes the row
// named by row_select from b_0..b_3; command accumulate carries one k step,
// each cell doing a single-rounded fma with its accumulator.
// o_out (fga_if source): one beat per emitted element, row-major, with
// last_result on the final one; only after an accumulate with last_step.
// config: i_cfg_we/i_cfg_idx/i_cfg_data write rows_active (0), cols_active
// (1); values are clamped to 1..tile size when used.
// an accumulate item passes the lane array in order: multiply, align-add,
// normalize, round and write-back, one lane per cell, all cells at once;
// a preload is written from the beat as it is taken. emission then runs one
// element per cycle while the receiver is ready. a new beat is taken only
// in idle, after the write-back and any emission of the last accumulate.
// reset: accumulators go to +0, rows/cols active to 4, block idle.
// a stalled receiver holds the output beat; the block waits in emission.
module fp32_gemm_tile_accumulator
    import fga_pkg::*;
#(
    parameter int TILE_ROWS = 4,
    parameter int TILE_COLS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fga_if.sink         i_in,
    fga_if.source       o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [2:0]  i_cfg_data
);
`include "fp32_gemm_tile_accumulator_assert.svh"
    localparam int ER = (TILE_ROWS < LANES) ? TILE_ROWS : LANES;
    localparam int EC = (TILE_COLS < LANES) ? TILE_COLS : LANES;

    t_state r_state, n_state;
    logic [1:0] r_phase, n_phase;
    logic [2:0] r_rows, r_cols;
    logic [1:0] r_er, n_er, r_ec, n_ec;
    logic [1:0] r_lr, n_lr, r_lc, n_lc;
    logic [31:0] r_acc [LANES*LANES];
    t_in_beat r_item;
    logic [31:0] w_res [LANES*LANES];
    logic [31:0] w_a [LANES];
    logic [31:0] w_b [LANES];

    always_comb begin
        w_a[0] = r_item.a_0; w_a[1] = r_item.a_1;
        w_a[2] = r_item.a_2; w_a[3] = r_item.a_3;
        w_b[0] = r_item.b_0; w_b[1] = r_item.b_1;
        w_b[2] = r_item.b_2; w_b[3] = r_item.b_3;
    end

    // one fma lane per cell
    for (genvar g = 0; g < LANES*LANES; g++) begin : g_lane
        fga_fma_lane u_lane (
            .i_clk  (i_clk),
            .i_phase(r_phase),
            .i_a    (w_a[g / LANES]),
            .i_b    (w_b[g % LANES]),
            .i_c    (r_acc[g]),
            .o_res  (w_res[g])
        );
    end

    // clamp active counts to 1..tile
    logic [2:0] w_nr, w_nc;
    always_comb begin
        w_nr = (r_rows == 3'd0) ? 3'd1 : (r_rows > 3'(ER)) ? 3'(ER) : r_rows;
        w_nc = (r_cols == 3'd0) ? 3'd1 : (r_cols > 3'(EC)) ? 3'(EC) : r_cols;
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_er = r_er; n_ec = r_ec; n_lr = r_lr; n_lc = r_lc;
        i_in.ready = r_state == ST_IDLE;
        unique case (r_state)
            ST_IDLE: begin
                n_phase = 2'd0;
                if (i_in.valid && i_in.data.command == CMD_ACC) n_state = ST_MUL;
            end
            ST_MUL: begin n_phase = 2'd1; n_state = ST_ALIGN; end
            ST_ALIGN: begin n_phase = 2'd2; n_state = ST_NORM; end
            ST_NORM: begin n_phase = 2'd3; n_state = ST_ROUND; end
            ST_ROUND: begin
                n_phase = 2'd0;
                n_state = r_item.last_step ? ST_EMIT : ST_IDLE;
                n_er = 2'd0; n_ec = 2'd0;
                n_lr = 2'(w_nr - 3'd1); n_lc = 2'(w_nc - 3'd1);
            end
            ST_EMIT: begin
                if (o_out.ready) begin
                    if (r_ec == r_lc) begin
                        n_ec = 2'd0;
                        if (r_er == r_lr) n_state = ST_IDLE;
                        else n_er = r_er + 2'd1;
                    end else begin
                        n_ec = r_ec + 2'd1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_out.valid = r_state == ST_EMIT;
        o_out.data.out_row = r_er;
        o_out.data.out_col = r_ec;
        o_out.data.c_value = r_acc[{r_er, r_ec}];
        o_out.data.last_result = r_er == r_lr && r_ec == r_lc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= 2'd0;
            r_rows <= 3'd4;
            r_cols <= 3'd4;
            r_er <= '0; r_ec <= '0; r_lr <= '0; r_lc <= '0;
            for (int i = 0; i < LANES*LANES; i++) r_acc[i] <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_er <= n_er; r_ec <= n_ec; r_lr <= n_lr; r_lc <= n_lc;
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_ROWS) r_rows <= i_cfg_data;
                else r_cols <= i_cfg_data;
            end
            // preload row write
            if (i_in.valid && i_in.ready && i_in.data.command == CMD_PRELOAD
                    && 32'(i_in.data.row_select) < 32'(ER)) begin
                for (int c = 0; c < EC; c++) begin
                    r_acc[{i_in.data.row_select, 2'(c)}] <=
                        (c == 0) ? i_in.data.b_0 : (c == 1) ? i_in.data.b_1 :
                        (c == 2) ? i_in.data.b_2 : i_in.data.b_3;
                end
            end
            // write back of the fma results for every cell inside the tile
            if (r_state == ST_ROUND) begin
                for (int i = 0; i < LANES*LANES; i++) begin
                    if (i / LANES < ER && i % LANES < EC) r_acc[i] <= w_res[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) r_item <= i_in.data;
    end

    `FGA_ASSERT_IMP(a_no_take_busy, i_clk, i_rst_n,
        r_state != ST_IDLE, !i_in.ready, "input taken while busy")
    `FGA_ASSERT_IMP(a_emit_bounds, i_clk, i_rst_n,
        o_out.valid, r_er <= r_lr && r_ec <= r_lc, "emit index past active tile")
    `FGA_ASSERT_NXT(a_emit_done, i_clk, i_rst_n,
        o_out.valid && o_out.ready && o_out.data.last_result,
        r_state == ST_IDLE, "emission did not end after last beat")
endmodule

[hw/rtl/fga_fma_lane.sv]
module fga_fma_lane
    import fga_pkg::*;
(
    input  logic        i_clk,
    input  logic [1:0]  i_phase,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    output logic [31:0] o_res
);
    // phase 0 multiply, 1 align and add, 2 normalize, 3 round
    t_mul r_mul, n_mul;
    t_sum r_sum, n_sum;
    logic [75:0] r_norm, n_norm;
    logic signed [11:0] r_ne, n_ne;
    logic [6:0] r_shamt, n_shamt;
    logic r_nshr, n_nshr;

    logic       sa, sb, sc;
    logic [7:0] ea, eb, ec;
    logic [22:0] fa, fb, fc;
    logic ainf, binf, cinf, azero, bzero, czero;

    always_comb begin
        sa = i_a[31]; sb = i_b[31]; sc = i_c[31];
        ea = i_a[30:23]; eb = i_b[30:23]; ec = i_c[30:23];
        fa = i_a[22:0]; fb = i_b[22:0]; fc = i_c[22:0];
        ainf = ea == 8'hFF; binf = eb == 8'hFF; cinf = ec == 8'hFF;
        azero = ea == 8'd0 && fa == 23'd0;
        bzero = eb == 8'd0 && fb == 23'd0;
        czero = ec == 8'd0 && fc == 23'd0;
        n_mul = '0;
        n_mul.ps = sa ^ sb;
        n_mul.sc = sc;
        n_mul.czero = czero;
        n_mul.prod = {(ea != 8'd0), fa} * {(eb != 8'd0), fb};
        // product value prod * 2^(xe), lsb weight
        n_mul.xe = 12'($signed({4'd0, (ea != 8'd0) ? ea : 8'd1}))
                 + 12'($signed({4'd0, (eb != 8'd0) ? eb : 8'd1})) - 12'sd300;
        n_mul.cm = {(ec != 8'd0), fc};
        n_mul.ye = 12'($signed({4'd0, (ec != 8'd0) ? ec : 8'd1})) - 12'sd150;
        if (ainf && fa != 23'd0) begin
            n_mul.special = 1'b1; n_mul.special_val = i_a | QNAN_BIT;
        end else if (binf && fb != 23'd0) begin
            n_mul.special = 1'b1; n_mul.special_val = i_b | QNAN_BIT;
        end else if (cinf && fc != 23'd0) begin
            n_mul.special = 1'b1; n_mul.special_val = i_c | QNAN_BIT;
        end else if ((ainf && bzero) || (binf && azero)) begin
            n_mul.special = 1'b1; n_mul.special_val = DEFAULT_NAN;
        end else if (ainf || binf) begin
            n_mul.special = 1'b1;
            n_mul.special_val = (cinf && sc != (sa ^ sb)) ? DEFAULT_NAN
                              : {sa ^ sb, 8'hFF, 23'd0};
        end else if (cinf) begin
            n_mul.special = 1'b1; n_mul.special_val = i_c;
        end else if (azero || bzero) begin
            n_mul.special = 1'b1;
            n_mul.special_val = czero ? {(sa ^ sb) & sc, 31'd0} : i_c;
        end
    end

    // align: both operands placed in a 76-bit window, lsb weight 2^(re)
    logic [75:0] xw, yw, big, sml, shd;
    logic signed [11:0] bige, smle, d;
    logic bigs, smls, sticky;
    logic [75:0] mask;

    always_comb begin
        xw = {28'd0, r_mul.prod};
        yw = {52'd0, r_mul.cm};
        mask = '0;
        // shift each operand up so common window has top room
        if (r_mul.xe - 12'sd48 >= r_mul.ye - 12'sd72) begin
            big = xw << 26; bige = r_mul.xe - 12'sd26; bigs = r_mul.ps;
            sml = yw << 50; smle = r_mul.ye - 12'sd50; smls = r_mul.sc;
        end else begin
            big = yw << 50; bige = r_mul.ye - 12'sd50; bigs = r_mul.sc;
            sml = xw << 26; smle = r_mul.xe - 12'sd26; smls = r_mul.ps;
        end
        d = smle - bige;
        // negative d: small operand lies below big's window
        if (d >= 0) begin
            shd = sml << d[6:0];
            sticky = 1'b0;
            if (d > 12'sd75) shd = '0;
        end else if (-d >= 12'sd76) begin
            shd = '0; sticky = sml != '0;
        end else begin
            mask = (76'd1 << 7'(-d)) - 76'd1;
            shd = sml >> 7'(-d);
            sticky = (sml & mask) != '0;
        end
        n_sum = '0;
        n_sum.special = r_mul.special;
        n_sum.special_val = r_mul.special_val;
        n_sum.re = bige;
        if (r_mul.czero) begin
            // zero addend: the product alone is rounded
            n_sum.r = xw << 26; n_sum.re = r_mul.xe - 12'sd26; n_sum.rs = r_mul.ps;
        end else if (bigs == smls) begin
            n_sum.r = big + shd; n_sum.r[0] = n_sum.r[0] | sticky; n_sum.rs = bigs;
        end else if (big >= {shd[75:1], shd[0] | sticky}) begin
            n_sum.r = big - shd - {75'd0, sticky};
            n_sum.r[0] = n_sum.r[0] | sticky; n_sum.rs = bigs;
        end else begin
            n_sum.r = shd - big; n_sum.rs = smls;
        end
        n_sum.zero_sum = n_sum.r == '0 && !sticky;
    end

    // normalize: find top bit, shift so its weight stays known
    logic [6:0] top;
    logic signed [11:0] s;
    always_comb begin
        top = '0;
        for (int i = 0; i < 76; i++) begin
            if (r_sum.r[i]) top = 7'(i);
        end
        s = 12'($signed({5'd0, top})) - 12'sd23;
        if (s < -12'sd149 - r_sum.re) s = -12'sd149 - r_sum.re;
        n_nshr = s > 0;
        n_shamt = (s > 0) ? ((s > 12'sd76) ? 7'd127 : s[6:0])
                          : ((-s > 12'sd75) ? 7'd76 : 7'(-s));
        n_norm = r_sum.r;
        n_ne = r_sum.re + s + 12'sd150;
    end

    logic [75:0] q, rem, half;
    logic [31:0] m;
    always_comb begin
        q = '0; rem = '0; half = '0;
        if (!r_nshr) begin
            m = 32'(r_norm << r_shamt);
        end else if (r_shamt > 7'd76) begin
            // shifted past the whole window, rounds to zero
            m = '0;
        end else begin
            q = r_norm >> r_shamt;
            half = 76'd1 << (r_shamt - 7'd1);
            rem = r_norm & ((76'd1 << r_shamt) - 76'd1);
            if (rem > half || (rem == half && q[0])) q = q + 76'd1;
            m = 32'(q);
        end
        if (r_sum.special) o_res = r_sum.special_val;
        else if (r_sum.zero_sum) o_res = r_mul.czero ? {r_sum.rs, 31'd0} : 32'd0;
        else if (r_ne >= 12'sd255) o_res = {r_sum.rs, 8'hFF, 23'd0};
        else if (m == '0) o_res = {r_sum.rs, 31'd0};
        else o_res = {r_sum.rs, 31'd0} | ((32'(r_ne - 12'sd1) << 23) + m);
    end

    always_ff @(posedge i_clk) begin
        if (i_phase == 2'd0) r_mul <= n_mul;
        if (i_phase == 2'd1) r_sum <= n_sum;
        if (i_phase == 2'd2) begin
            r_norm <= n_norm; r_ne <= n_ne; r_shamt <= n_shamt; r_nshr <= n_nshr;
        end
    end
endmodule

[test/testbench.sv]
// scoreboard for the tile accumulator: keeps its own copy of the accumulator
// grid and the active counts, predicts the emitted elements of each tile
class tile_scoreboard;
    logic [31:0]          acc_grid [16];
    logic [2:0]           row_limit;
    logic [2:0]           col_limit;
    fga_pkg::t_out_beat   pending_c [$];
    int                   errors;
    int                   tiles_done;
    int                   elems_done;

    function new();
        foreach (acc_grid[i]) acc_grid[i] = '0;
        row_limit = 3'd4;
        col_limit = 3'd4;
        errors = 0;
        tiles_done = 0;
        elems_done = 0;
    endfunction

    static function int msb_index(logic [63:0] v);
        int p;
        p = -1;
        for (int i = 0; i < 64; i++) if (v[i]) p = i;
        return p;
    endfunction

    // single-rounded a*b+c, round to nearest even, subnormals kept
    static function logic [31:0] fused_mul_add(logic [31:0] a, logic [31:0] b,
                                               logic [31:0] c);
        logic        sa, sb, sc, ps, rs, ts, ainf, binf, cinf, azero, bzero, czero;
        int          ea, eb, ec, xe, ye, re, p, s, e, te, d;
        logic [22:0] fa, fb, fc;
        logic [63:0] x, y, r, t, q, rem, half;
        logic [31:0] m;
        sa = a[31]; sb = b[31]; sc = c[31];
        ea = a[30:23]; eb = b[30:23]; ec = c[30:23];
        fa = a[22:0]; fb = b[22:0]; fc = c[22:0];
        ainf = ea == 255; binf = eb == 255; cinf = ec == 255;
        azero = ea == 0 && fa == 0;
        bzero = eb == 0 && fb == 0;
        czero = ec == 0 && fc == 0;
        ps = sa ^ sb;
        // nan propagation, then invalid operations and infinities
        if (ainf && fa != 0) return a | fga_pkg::QNAN_BIT;
        if (binf && fb != 0) return b | fga_pkg::QNAN_BIT;
        if (cinf && fc != 0) return c | fga_pkg::QNAN_BIT;
        if ((ainf && bzero) || (binf && azero)) return fga_pkg::DEFAULT_NAN;
        if (ainf || binf) begin
            if (cinf && sc != ps) return fga_pkg::DEFAULT_NAN;
            return {ps, 31'h7F800000};
        end
        if (cinf) return c;
        if (azero || bzero) begin
            if (czero) return {ps & sc, 31'd0};
            return c;
        end
        // exact product, normalized so bit 57 is the leading one
        x = {40'd0, (ea != 0), fa} * {40'd0, (eb != 0), fb};
        xe = (ea != 0 ? ea : 1) + (eb != 0 ? eb : 1) - 300;
        p = msb_index(x);
        x = x << (57 - p);
        xe -= 57 - p;
        if (czero) begin
            r = x; re = xe; rs = ps;
        end else begin
            y = {40'd0, (ec != 0), fc};
            ye = (ec != 0 ? ec : 1) - 150;
            p = msb_index(y);
            y = y << (57 - p);
            ye -= 57 - p;
            if (xe < ye) begin
                t = x; te = xe; ts = ps;
                x = y; xe = ye; ps = sc;
                y = t; ye = te; sc = ts;
            end
            d = xe - ye;
            // align the smaller addend with a sticky bit
            if (d >= 58) y = 64'd1;
            else if (d > 0) y = (y >> d) | 64'((y & ((64'd1 << d) - 64'd1)) != 0);
            re = xe;
            if (ps == sc) begin
                r = x + y; rs = ps;
            end else if (x >= y) begin
                r = x - y; rs = ps;
            end else begin
                r = y - x; rs = sc;
            end
            if (r == 0) return 32'd0;
        end
        p = msb_index(r);
        s = p - 23;
        if (s < -149 - re) s = -149 - re;
        if (s <= 0) begin
            m = 32'(r << (-s));
        end else if (s > 60) begin
            m = 32'd0;
        end else begin
            q = r >> s;
            rem = r & ((64'd1 << s) - 64'd1);
            half = 64'd1 << (s - 1);
            if (rem > half || (rem == half && q[0])) q = q + 64'd1;
            m = 32'(q);
        end
        e = re + s + 150;
        if (e >= 255) return {rs, 31'h7F800000};
        if (m == 0) return {rs, 31'd0};
        return {rs, 31'd0} | ((32'(e - 1) << 23) + m);
    endfunction

    function void write_reg(logic idx, logic [2:0] val);
        if (idx == fga_pkg::REG_ROWS) row_limit = val;
        else col_limit = val;
    endfunction

    function void note_beat(fga_pkg::t_in_beat bt);
        logic [31:0]        av [4];
        logic [31:0]        bv [4];
        int                 nr, nc;
        fga_pkg::t_out_beat ob;
        av = '{bt.a_0, bt.a_1, bt.a_2, bt.a_3};
        bv = '{bt.b_0, bt.b_1, bt.b_2, bt.b_3};
        if (bt.command == fga_pkg::CMD_PRELOAD) begin
            for (int cc = 0; cc < 4; cc++) acc_grid[bt.row_select * 4 + cc] = bv[cc];
            return;
        end
        for (int rr = 0; rr < 4; rr++)
            for (int cc = 0; cc < 4; cc++)
                acc_grid[rr * 4 + cc] = fused_mul_add(av[rr], bv[cc], acc_grid[rr * 4 + cc]);
        if (!bt.last_step) return;
        nr = row_limit < 1 ? 1 : (row_limit > 4 ? 4 : row_limit);
        nc = col_limit < 1 ? 1 : (col_limit > 4 ? 4 : col_limit);
        for (int rr = 0; rr < nr; rr++)
            for (int cc = 0; cc < nc; cc++) begin
                ob.out_row = 2'(rr);
                ob.out_col = 2'(cc);
                ob.c_value = acc_grid[rr * 4 + cc];
                ob.last_result = (rr == nr - 1) && (cc == nc - 1);
                pending_c.push_back(ob);
            end
        tiles_done++;
    endfunction

    function void check_beat(fga_pkg::t_out_beat got);
        fga_pkg::t_out_beat want;
        if (pending_c.size() == 0) begin
            $error("unexpected output beat row %0d col %0d value %h",
                   got.out_row, got.out_col, got.c_value);
            errors++;
            return;
        end
        want = pending_c.pop_front();
        elems_done++;
        if (got.out_row !== want.out_row) begin
            $error("out_row expected %0d actual %0d", want.out_row, got.out_row);
            errors++;
        end
        if (got.out_col !== want.out_col) begin
            $error("out_col expected %0d actual %0d", want.out_col, got.out_col);
            errors++;
        end
        if (got.c_value !== want.c_value) begin
            $error("c_value expected %h actual %h", want.c_value, got.c_value);
            errors++;
        end
        if (got.last_result !== want.last_result) begin
            $error("last_result expected %0d actual %0d", want.last_result, got.last_result);
            errors++;
        end
    endfunction
endclass

module testbench;
    import fga_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [2:0] i_cfg_data;

    fga_if #(.T(t_in_beat))  in_ch ();
    fga_if #(.T(t_out_beat)) out_ch ();

    fp32_gemm_tile_accumulator i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    tile_scoreboard sb = new();
    int  beats_sent;
    bit  steady_phase;  // no gaps on either side while set
    int  stall_left;

    always #1 i_clk = ~i_clk;

    // gap length: mostly zero or short, now and then long
    function automatic int gap_len();
        int pick;
        if (steady_phase) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // operand mix: raw bits, special encodings, and moderate normal values
    function automatic logic [31:0] rand_operand();
        logic [31:0] specials [12];
        specials = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000,
                     32'h7FC00000, 32'h7F800001, 32'hFF812345, 32'h00000001,
                     32'h807FFFFF, 32'h7F7FFFFF, 32'h00800000, 32'hFFFFFFFF};
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return specials[$urandom_range(0, 11)];
            default: return {1'($urandom), 8'($urandom_range(112, 142)), 23'($urandom)};
        endcase
    endfunction

    function automatic t_in_beat make_beat(logic cmd, logic [1:0] row, logic [31:0] a0,
                                           logic [31:0] a1, logic [31:0] a2,
                                           logic [31:0] a3, logic [31:0] b0,
                                           logic [31:0] b1, logic [31:0] b2,
                                           logic [31:0] b3, logic last);
        t_in_beat bt;
        bt = '{command: cmd, row_select: row, a_0: a0, a_1: a1, a_2: a2, a_3: a3,
               b_0: b0, b_1: b1, b_2: b2, b_3: b3, last_step: last};
        return bt;
    endfunction

    function automatic t_in_beat rand_beat(logic cmd, logic last);
        return make_beat(cmd, 2'($urandom), rand_operand(), rand_operand(), rand_operand(),
                         rand_operand(), rand_operand(), rand_operand(), rand_operand(),
                         rand_operand(), last);
    endfunction

    // drive one beat, hold until taken, then an optional gap
    task automatic send_beat(t_in_beat bt);
        int gap;
        in_ch.valid <= 1'b1;
        in_ch.data  <= bt;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_beat(bt);
        beats_sent++;
        gap = gap_len();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // drain all results, then give the lane array time to finish a silent step
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_c.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // both registers, back to back
    task automatic write_regs(logic [2:0] rows, logic [2:0] cols);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_ROWS;
        i_cfg_data <= rows;
        @(posedge i_clk);
        sb.write_reg(REG_ROWS, rows);
        i_cfg_idx  <= REG_COLS;
        i_cfg_data <= cols;
        @(posedge i_clk);
        sb.write_reg(REG_COLS, cols);
        i_cfg_we   <= 1'b0;
    endtask

    // receiver: random stalls, checked on every accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) sb.check_beat(out_ch.data);
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left   <= stall_left - 1;
            end else begin
                out_ch.ready <= 1'b1;
                stall_left   <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            end
        end
    end

    initial begin
        #5ms;
        $display("testbench: errors");
        $finish;
    end

    initial begin
        logic [2:0] rsel [6];
        logic [2:0] csel [6];
        int         k_steps;
        t_in_beat   bt;
        rsel = '{3'd4, 3'd2, 3'd1, 3'd3, 3'd0, 3'd7};
        csel = '{3'd4, 3'd3, 3'd4, 3'd1, 3'd5, 3'd0};
        beats_sent   = 0;
        steady_phase = 1'b0;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= REG_ROWS;
        i_cfg_data  <= 3'd0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset tile first, then specials through preload and fma
        send_beat(make_beat(CMD_ACC, 2'd0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        send_beat(make_beat(CMD_PRELOAD, 2'd0, 0, 0, 0, 0, 32'h3F800000, 32'h80000000,
                            32'h7F800000, 32'h7F800001, 1'b0));
        send_beat(make_beat(CMD_PRELOAD, 2'd1, 0, 0, 0, 0, 32'hFF800000, 32'h00000001,
                            32'h7F7FFFFF, 32'h80000000, 1'b0));
        // preload with last_step set emits nothing
        send_beat(make_beat(CMD_PRELOAD, 2'd2, '1, '1, '1, '1, 0, 0, 0, 0, 1'b1));
        send_beat(make_beat(CMD_PRELOAD, 2'd3, 0, 0, 0, 0, 32'h807FFFFF, 32'hFFFFFFFF,
                            32'h3F800000, 32'h00800000, 1'b0));
        // inf times zero, inf against opposite inf, zero sums, overflow
        send_beat(make_beat(CMD_ACC, 2'd0, 32'h00000000, 32'h7F800000, 32'h80000000,
                            32'h7F7FFFFF, 32'h7F800000, 32'h00000000, 32'h80000000,
                            32'h7F7FFFFF, 1'b0));
        // nan operands, subnormal products, cancellation
        send_beat(make_beat(CMD_ACC, 2'd0, 32'h7FC00000, 32'h00000001, 32'h3F800000,
                            32'hBF800000, 32'h00000001, 32'h80800000, 32'hFF800000,
                            32'h3F800000, 1'b1));
        send_beat(make_beat(CMD_ACC, 2'd0, 32'h00800001, 32'h80000001, 32'h7F7FFFFF,
                            32'h3F800001, 32'h00400000, 32'h3F000000, 32'hBF800000,
                            32'h3F7FFFFF, 1'b1));
        send_beat(make_beat(CMD_ACC, 2'd3, '1, 0, 32'hFF812345, 32'h80000000,
                            32'h80000000, '1, 32'h80000000, 32'h80000000, 1'b1));
        wait_idle();
        // smallest tile, then out-of-range counts that clamp
        write_regs(3'd1, 3'd1);
        send_beat(rand_beat(CMD_ACC, 1'b1));
        wait_idle();
        write_regs(3'd0, 3'd7);
        send_beat(rand_beat(CMD_ACC, 1'b1));
        wait_idle();
        write_regs(3'd7, 3'd0);
        send_beat(rand_beat(CMD_ACC, 1'b1));
        wait_idle();
        write_regs(3'd4, 3'd4);
        steady_phase = 1'b1;
        send_beat(rand_beat(CMD_ACC, 1'b0));
        send_beat(rand_beat(CMD_ACC, 1'b1));
        steady_phase = 1'b0;

        // random tiles: preloads, a few k steps, then the final one; some noise
        for (int phase = 0; phase < 6; phase++) begin
            wait_idle();
            write_regs(phase < 2 ? rsel[phase] : 3'($urandom),
                       phase < 2 ? csel[phase] : 3'($urandom));
            steady_phase = (phase == 3);
            while (beats_sent < 20 + 58 * (phase + 1)) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_beat(rand_beat(1'($urandom), 1'($urandom)));
                end else begin
                    for (int rr = 0; rr < 4; rr++)
                        if ($urandom_range(0, 2) == 0) begin
                            bt = rand_beat(CMD_PRELOAD, 1'($urandom));
                            bt.row_select = 2'(rr);
                            send_beat(bt);
                        end
                    k_steps = $urandom_range(1, 5);
                    for (int k = 0; k < k_steps; k++)
                        send_beat(rand_beat(CMD_ACC, k == k_steps - 1));
                end
            end
        end
        steady_phase = 1'b0;

        wait_idle();
        $display("run covered %0d input beats, %0d tiles, %0d checked elements",
                 beats_sent, sb.tiles_done, sb.elems_done);
        $display("over clamped and full active counts with preloads and fp specials");
        if (sb.errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule
